// File: hw/rtl/ipd_pkg.sv
// shared types, constants and character tables of the ipd frame deframer
package ipd_pkg;

    // width of the parsed payload length
    localparam int LENGTH_WIDTH = 16;
    // largest length the counters can hold
    localparam logic [15:0] LENGTH_CAP = 16'((64'd1 << LENGTH_WIDTH) - 64'd1);
    // digit accumulation needs four extra bits for times ten plus a digit
    localparam int ACCUM_WIDTH = LENGTH_WIDTH + 4;

    // reset value of max_payload
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    // queue depth between parser and output stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // header characters
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_I     = 8'h49;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_C     = 8'h43;

    // last character positions in "IPD" and "TCP:"
    localparam logic [1:0] PREFIX_LAST_POS = 2'd2;
    localparam logic [1:0] TAIL_LAST_POS   = 2'd3;

    // classified request passed from parser to output stage
    typedef enum logic [1:0] {
        OP_PAYLOAD      = 2'b00,
        OP_PAYLOAD_LAST = 2'b01,
        OP_BAD_HEADER   = 2'b10
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } queue_entry_t;

    // result kind codes
    localparam logic KIND_PAYLOAD    = 1'b0;
    localparam logic KIND_BAD_HEADER = 1'b1;

    // expected character of "IPD" at a position
    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = CHAR_I;
            2'd1:    c = CHAR_P;
            2'd2:    c = CHAR_D;
            default: c = CHAR_D;
        endcase
        return c;
    endfunction

    // expected character of "TCP:" at a position
    function automatic logic [7:0] tail_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = CHAR_T;
            2'd1:    c = CHAR_C;
            2'd2:    c = CHAR_P;
            default: c = CHAR_COLON;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/ipd_parser.sv
// front part: header parser that turns payload bytes and header errors into queue requests
module ipd_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_byte_in,
    input  logic                  queue_full,
    output logic                  push,
    output ipd_pkg::queue_entry_t push_entry
);

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_PREFIX  = 6'b000010,
        PH_COMMA   = 6'b000100,
        PH_DIGITS  = 6'b001000,
        PH_TAIL    = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    localparam logic [ipd_pkg::LENGTH_WIDTH-1:0] ONE_LEN = ipd_pkg::LENGTH_WIDTH'(1);

    phase_t                              phase_reg, phase_next;
    logic [1:0]                          pos_reg, pos_next;
    logic [ipd_pkg::LENGTH_WIDTH-1:0]    accum_reg, accum_next;
    logic [ipd_pkg::LENGTH_WIDTH-1:0]    remain_reg, remain_next;
    logic [15:0]                         max_payload_reg;

    logic                                accept;
    logic [7:0]                          b;
    logic                                is_digit;
    logic [ipd_pkg::LENGTH_WIDTH-1:0]    limit;
    logic [ipd_pkg::ACCUM_WIDTH-1:0]     accum_wide;
    logic [ipd_pkg::ACCUM_WIDTH-1:0]     digit_sum;
    phase_t                              rehunt_phase;

    assign cfg_ready = 1'b1;
    assign s_ready   = !queue_full;
    assign accept    = s_valid && s_ready;
    assign b         = s_byte_in;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= ipd_pkg::MAX_PAYLOAD_RESET;
        end else if (cfg_valid) begin
            max_payload_reg <= cfg_data;
        end
    end

    // effective length limit and next accumulated length
    always_comb begin
        if (max_payload_reg > ipd_pkg::LENGTH_CAP) begin
            limit = ipd_pkg::LENGTH_CAP[ipd_pkg::LENGTH_WIDTH-1:0];
        end else begin
            limit = max_payload_reg[ipd_pkg::LENGTH_WIDTH-1:0];
        end
        is_digit   = (b >= ipd_pkg::CHAR_ZERO) && (b <= ipd_pkg::CHAR_NINE);
        accum_wide = {4'd0, accum_reg};
        digit_sum  = (accum_wide << 3) + (accum_wide << 1)
                   + {{(ipd_pkg::ACCUM_WIDTH-4){1'b0}}, b[3:0]};
        rehunt_phase = (b == ipd_pkg::CHAR_PLUS) ? PH_PREFIX : PH_HUNT;
    end

    // parser next state and request
    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        accum_next      = accum_reg;
        remain_next     = remain_reg;
        push            = 1'b0;
        push_entry.op   = ipd_pkg::OP_BAD_HEADER;
        push_entry.data = b;
        if (accept) begin
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (b == ipd_pkg::prefix_char(pos_reg)) begin
                        if (pos_reg == ipd_pkg::PREFIX_LAST_POS) begin
                            pos_next   = 2'd0;
                            phase_next = PH_COMMA;
                        end else begin
                            pos_next = pos_reg + 2'd1;
                        end
                    end else begin
                        pos_next   = 2'd0;
                        phase_next = rehunt_phase;
                    end
                end
                PH_COMMA: begin
                    if (b == ipd_pkg::CHAR_COMMA) begin
                        accum_next = '0;
                        phase_next = PH_DIGITS;
                    end else begin
                        push       = 1'b1;
                        pos_next   = 2'd0;
                        phase_next = rehunt_phase;
                    end
                end
                PH_DIGITS: begin
                    priority if (is_digit &&
                                 digit_sum <= {4'd0, limit}) begin
                        accum_next = digit_sum[ipd_pkg::LENGTH_WIDTH-1:0];
                    end else if (!is_digit && b == ipd_pkg::CHAR_COMMA &&
                                 accum_reg != '0) begin
                        pos_next   = 2'd0;
                        phase_next = PH_TAIL;
                    end else begin
                        push       = 1'b1;
                        pos_next   = 2'd0;
                        phase_next = rehunt_phase;
                    end
                end
                PH_TAIL: begin
                    if (b == ipd_pkg::tail_char(pos_reg)) begin
                        if (pos_reg == ipd_pkg::TAIL_LAST_POS) begin
                            pos_next    = 2'd0;
                            remain_next = accum_reg;
                            phase_next  = PH_PAYLOAD;
                        end else begin
                            pos_next = pos_reg + 2'd1;
                        end
                    end else begin
                        push       = 1'b1;
                        pos_next   = 2'd0;
                        phase_next = rehunt_phase;
                    end
                end
                PH_PAYLOAD: begin
                    push = 1'b1;
                    if (remain_reg <= ONE_LEN) begin
                        push_entry.op = ipd_pkg::OP_PAYLOAD_LAST;
                        remain_next   = '0;
                        phase_next    = PH_HUNT;
                    end else begin
                        push_entry.op = ipd_pkg::OP_PAYLOAD;
                        remain_next   = remain_reg - ONE_LEN;
                    end
                end
                default: begin
                    pos_next   = 2'd0;
                    phase_next = rehunt_phase;
                end
            endcase
        end
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            pos_reg    <= 2'd0;
            accum_reg  <= '0;
            remain_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            accum_reg  <= accum_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// File: hw/rtl/ipd_queue.sv
// short request queue between parser and output stage
module ipd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ipd_pkg::queue_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output ipd_pkg::queue_entry_t pop_entry
);

    ipd_pkg::queue_entry_t            entries [ipd_pkg::QUEUE_DEPTH];
    logic [ipd_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ipd_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ipd_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                             do_push, do_pop;

    localparam logic [ipd_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
        ipd_pkg::QUEUE_CNT_W'(ipd_pkg::QUEUE_DEPTH);
    localparam logic [ipd_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        ipd_pkg::QUEUE_PTR_W'(ipd_pkg::QUEUE_DEPTH - 1);
    localparam logic [ipd_pkg::QUEUE_CNT_W-1:0] ONE_CNT =
        ipd_pkg::QUEUE_CNT_W'(1);

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = entries[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + ONE_CNT;
            2'b01:   count_next = count_reg - ONE_CNT;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/ipd_emit.sv
// back part: turns queued requests into result fields in an output register
module ipd_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  not_empty,
    input  ipd_pkg::queue_entry_t pop_entry,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [7:0]            m_payload_byte,
    output logic                  m_last
);

    logic       valid_reg;
    logic       kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;

    assign pop            = not_empty && (!valid_reg || m_ready);
    assign m_valid        = valid_reg;
    assign m_kind         = kind_reg;
    assign m_payload_byte = byte_reg;
    assign m_last         = last_reg;

    // decode request into result fields
    always_comb begin
        unique case (pop_entry.op)
            ipd_pkg::OP_PAYLOAD: begin
                kind_next = ipd_pkg::KIND_PAYLOAD;
                byte_next = pop_entry.data;
                last_next = 1'b0;
            end
            ipd_pkg::OP_PAYLOAD_LAST: begin
                kind_next = ipd_pkg::KIND_PAYLOAD;
                byte_next = pop_entry.data;
                last_next = 1'b1;
            end
            default: begin
                kind_next = ipd_pkg::KIND_BAD_HEADER;
                byte_next = 8'd0;
                last_next = 1'b0;
            end
        endcase
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

endmodule

// File: hw/rtl/ipd_frame_deframer_core.sv
// top level of the ipd frame deframer: parser, request queue and output stage
//
//   channel | direction | ports                                  | moves
//   cfg     | in        | cfg_valid cfg_ready cfg_data           | max_payload write
//   s       | in        | s_valid s_ready s_byte_in              | one stream byte
//   m       | out       | m_valid m_ready m_kind m_payload_byte  | one result
//           |           | m_last                                 |
//
// one byte per cycle while s_ready is high; the parser decides each byte in its accept cycle
// a byte's result reaches m_valid through a queue entry, then the output register
// s_ready drops only while the two-entry queue is full under m backpressure
// aresetn is synchronous; it clears all control state and sets max_payload to 1024
// config writes are taken every cycle and act on the next byte
module ipd_frame_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_payload_byte,
    output logic        m_last
);

    logic                  push;
    ipd_pkg::queue_entry_t push_entry;
    logic                  queue_full;
    logic                  pop;
    logic                  not_empty;
    ipd_pkg::queue_entry_t pop_entry;

    // header parser
    ipd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_in  (s_byte_in),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // request queue
    ipd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .pop_entry  (pop_entry)
    );

    // output stage
    ipd_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .not_empty      (not_empty),
        .pop_entry      (pop_entry),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_last         (m_last)
    );

endmodule
